@@ hw/rtl/gbcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_pkg
// Shared types and constants for the gyro bias calibration limiter.
// ----------------------------------------------------------------------------
package gbcl_pkg;

  localparam int AXES = 3;
  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int RAW_W  = 16;
  localparam int RATE_W = 24;
  localparam int SUM_W  = 32;
  localparam int SQ_W   = 48;
  localparam int N_W    = 16;
  localparam int THR_W  = 8;
  localparam int MUL_W  = 33;

  localparam logic signed [16:0] JUMP_LIMIT = 17'sd16384;
  localparam logic signed [MUL_W-1:0] RATE_SCALE = 33'sd100;
  localparam int YAW_AXIS = 2;

  localparam logic [N_W-1:0]   CAL_SAMPLES_RST = 16'd8000;
  localparam logic [THR_W-1:0] MOVE_THR_RST    = 8'd48;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_CAL    = 2'd1,
    FUNC_FIRST  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_CAL_SAMPLES = 2'd0,
    REG_MOVE_THR    = 2'd1,
    REG_YAW_OFFSET  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef logic signed [RATE_W-1:0] rate_t;

endpackage

@@ hw/rtl/gyro_bias_calibration_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibration_limiter
// Gyro zero-offset calibration with a spread check and a jump limiter.
// ----------------------------------------------------------------------------
// Input words carry a command in in_tuser and three raw axis samples in
// in_tdata. Every input word gives exactly one output word: three rates in
// hundredths of a count and three status flags. Registers are written on the cfg
// channel, always ready, only while the block is idle; the user must ensure it.
// One input word is processed at a time by a sequencer around one shared
// 33x33 multiplier and a one-bit-per-cycle divider:
//   command word             : straight to the output register
//   calibrated sample        : a multiply and an accumulate step per axis
//   calibration sample       : a square and an accumulate step per axis
//   final calibration sample : per axis a square and an accumulate, then 7
//                              spread-check multiplier steps and a 32-bit divide
// in_tready is high while the sequencer is idle. A finished word waits in the
// output register; the next input word is taken and worked on meanwhile, and
// its result waits until the output register is free.
// Reset (rst_n low, synchronous) restores the register defaults and leaves
// the block calibrated with zero offsets and no output word pending.
// ----------------------------------------------------------------------------
module gyro_bias_calibration_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // rate_x, rate_y, rate_z
  output logic [2:0]  out_tuser,  // calibrating, calibration_done, calibration_restarted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gbcl_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_RMUL  = 18'h00002,
    S_RACC  = 18'h00004,
    S_SQ    = 18'h00008,
    S_ACC   = 18'h00010,
    S_M1    = 18'h00020,
    S_M2    = 18'h00040,
    S_M3    = 18'h00080,
    S_M4    = 18'h00100,
    S_M5    = 18'h00200,
    S_M6    = 18'h00400,
    S_M7    = 18'h00800,
    S_DIVST = 18'h01000,
    S_DIV   = 18'h02000,
    S_ZERO  = 18'h04000,
    S_FIN   = 18'h08000,
    S_OUT   = 18'h10000,
    S_SPARE = 18'h20000
  } state_t;

  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  state_t state_r, state_nxt;

  logic [N_W-1:0]   n_r;
  logic [THR_W-1:0] thr_r;
  logic [15:0]      yaw_r;

  logic [N_W-1:0]   left_r;
  logic             first_arm_r;
  logic [SUM_W-1:0] sum_r  [AXES];
  logic [SQ_W-1:0]  sq_r   [AXES];
  logic [RAW_W-1:0] zero_r [AXES];
  logic [RAW_W-1:0] prev_r [AXES];

  logic [RAW_W-1:0] raw_r  [AXES];
  rate_t            rate_r [AXES];
  logic [AX_W-1:0]  ax_r;
  logic             first_r, final_r, done_r, rstd_r;

  logic [63:0]      sqm_r, lhs_r;
  logic [39:0]      hi_r;
  logic [31:0]      nn1_r;
  logic [31:0]      quo_r;
  logic [15:0]      rem_r;
  logic [4:0]       cnt_r;

  logic             out_tvalid_r;
  logic [71:0]      out_tdata_r;
  logic [2:0]       out_tuser_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  gbcl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  logic             in_acc;
  logic [1:0]       func_in;
  logic [SUM_W-1:0] mag;
  logic             chk_en;
  logic signed [16:0] d_jump;
  logic             jump;
  logic [RAW_W-1:0] lim;
  logic signed [16:0] lim_off;
  logic [16:0]      rem_sh;
  logic             div_ge;
  logic [64:0]      bound;
  logic             moved;
  logic             out_free;
  logic [71:0]      res_data;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign func_in   = in_tuser;
  assign out_free  = !out_tvalid_r || out_tready;

  assign mag    = sum_r[ax_r][SUM_W-1] ? (~sum_r[ax_r] + 32'd1) : sum_r[ax_r];
  assign chk_en = (thr_r != '0) && (n_r >= 16'd2);

  assign d_jump  = $signed({raw_r[ax_r][15], raw_r[ax_r]})
                 - $signed({prev_r[ax_r][15], prev_r[ax_r]});
  assign jump    = (d_jump > JUMP_LIMIT) || (d_jump < -JUMP_LIMIT);
  assign lim     = jump ? prev_r[ax_r] : raw_r[ax_r];
  assign lim_off = $signed({lim[15], lim}) - $signed({zero_r[ax_r][15], zero_r[ax_r]});

  assign rem_sh = {rem_r, quo_r[31]};
  assign div_ge = rem_sh >= {1'b0, n_r};

  assign bound = {1'b0, sqm_r} + {17'd0, mul_p[47:0]};
  assign moved = {1'b0, lhs_r} > bound;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RMUL: begin
        mul_a = MUL_W'(lim_off);
        mul_b = RATE_SCALE;
      end
      S_SQ: begin
        mul_a = MUL_W'($signed(raw_r[ax_r]));
        mul_b = MUL_W'($signed(raw_r[ax_r]));
      end
      S_M1: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({1'b0, mag});
      end
      S_M2: begin
        mul_a = $signed({17'd0, n_r});
        mul_b = $signed({9'd0, sq_r[ax_r][47:24]});
      end
      S_M3: begin
        mul_a = $signed({17'd0, n_r});
        mul_b = $signed({9'd0, sq_r[ax_r][23:0]});
      end
      S_M4: begin
        mul_a = $signed({17'd0, n_r});
        mul_b = $signed({17'd0, n_r - 16'd1});
      end
      S_M5: begin
        mul_a = $signed({25'd0, thr_r});
        mul_b = $signed({25'd0, thr_r});
      end
      S_M6: begin
        mul_a = $signed({17'd0, mul_p[15:0]});
        mul_b = $signed({1'b0, nn1_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (func_in == FUNC_SAMPLE) begin
            state_nxt = (left_r == '0) ? S_RMUL : S_SQ;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RMUL:  state_nxt = S_RACC;
      S_RACC:  state_nxt = (ax_r == AX_LAST) ? S_OUT : S_RMUL;
      S_SQ:    state_nxt = S_ACC;
      S_ACC: begin
        if (final_r) begin
          state_nxt = chk_en ? S_M1 : S_DIVST;
        end else begin
          state_nxt = (ax_r == AX_LAST) ? S_FIN : S_SQ;
        end
      end
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_M7;
      S_M7:    state_nxt = moved ? S_OUT : S_DIVST;
      S_DIVST: begin
        if (n_r == '0) begin
          state_nxt = (ax_r == AX_LAST) ? S_FIN : S_SQ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:   state_nxt = (cnt_r == 5'd31) ? S_ZERO : S_DIV;
      S_ZERO:  state_nxt = (ax_r == AX_LAST) ? S_FIN : S_SQ;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_data = '0;
    for (int a = 0; a < 3; a++) begin
      if (a < AXES) begin
        res_data[a*RATE_W +: RATE_W] = rate_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= CAL_SAMPLES_RST;
      thr_r        <= MOVE_THR_RST;
      yaw_r        <= '0;
      left_r       <= '0;
      first_arm_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a]  <= '0;
        sq_r[a]   <= '0;
        zero_r[a] <= '0;
        prev_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CAL_SAMPLES: n_r   <= cfg_data;
          REG_MOVE_THR:    thr_r <= cfg_data[THR_W-1:0];
          REG_YAW_OFFSET:  yaw_r <= cfg_data;
          REG_UNUSED:      ;
        endcase
      end

      if (state_r == S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ax_r    <= '0;
            done_r  <= 1'b0;
            rstd_r  <= 1'b0;
            first_r <= (left_r == n_r);
            final_r <= (left_r == 16'd1);
            for (int a = 0; a < AXES; a++) begin
              raw_r[a]  <= in_tdata[a*RAW_W +: RAW_W];
              rate_r[a] <= '0;
            end
            if (func_in == FUNC_CAL ||
                (func_in == FUNC_FIRST && !first_arm_r)) begin
              left_r <= n_r;
            end
            if (func_in == FUNC_FIRST) begin
              first_arm_r <= 1'b1;
            end
          end
        end
        S_RMUL: begin
          if (!jump) begin
            prev_r[ax_r] <= raw_r[ax_r];
          end
        end
        S_RACC: begin
          if (int'(ax_r) == YAW_AXIS) begin
            rate_r[ax_r] <= mul_p[RATE_W-1:0] + RATE_W'($signed(yaw_r));
          end else begin
            rate_r[ax_r] <= mul_p[RATE_W-1:0];
          end
          ax_r <= ax_r + AX_W'(1);
        end
        S_ACC: begin
          sum_r[ax_r] <= (first_r ? '0 : sum_r[ax_r])
                       + SUM_W'($signed(raw_r[ax_r]));
          sq_r[ax_r]  <= (first_r ? '0 : sq_r[ax_r]) + mul_p[SQ_W-1:0];
          if (first_r) begin
            zero_r[ax_r] <= '0;
          end
          if (!final_r) begin
            ax_r <= ax_r + AX_W'(1);
          end
        end
        S_M2: sqm_r <= mul_p[63:0];
        S_M3: hi_r  <= mul_p[39:0];
        S_M4: lhs_r <= {hi_r, 24'd0} + {24'd0, mul_p[39:0]};
        S_M5: nn1_r <= mul_p[31:0];
        S_M7: begin
          if (moved) begin
            left_r <= n_r;
            rstd_r <= 1'b1;
          end
        end
        S_DIVST: begin
          if (n_r == '0) begin
            zero_r[ax_r] <= '0;
            ax_r         <= ax_r + AX_W'(1);
          end
          quo_r <= mag;
          rem_r <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          rem_r <= div_ge ? 16'(rem_sh - {1'b0, n_r}) : rem_sh[15:0];
          quo_r <= {quo_r[30:0], div_ge};
          cnt_r <= cnt_r + 5'd1;
        end
        S_ZERO: begin
          zero_r[ax_r] <= sum_r[ax_r][SUM_W-1] ? 16'(~quo_r + 32'd1) : quo_r[15:0];
          ax_r         <= ax_r + AX_W'(1);
        end
        S_FIN: begin
          left_r <= left_r - 16'd1;
          done_r <= final_r;
        end
        S_OUT: begin
          if (out_free) begin
            out_tdata_r  <= res_data;
            out_tuser_r  <= {rstd_r, done_r, left_r != '0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("done and restart together");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("done while still calibrating");

  a_restart_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0])
    else $error("restart without calibration");

  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata == '0)
    else $error("nonzero rate during calibration");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("accepted word while busy");

endmodule

@@ hw/rtl/gbcl_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gbcl_mul (
  input  logic                                 clk,
  input  logic signed [gbcl_pkg::MUL_W-1:0]    a,
  input  logic signed [gbcl_pkg::MUL_W-1:0]    b,
  output logic signed [2*gbcl_pkg::MUL_W-1:0]  p_r
);
  import gbcl_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
